>>> design/l_shape_route_capacity_engine_top_assert.svh
// ----------------------------------------------------------------------------
// l_shape_route_capacity_engine_top_assert.svh
// assertion macros shared by the route capacity engine modules
// ----------------------------------------------------------------------------
`ifndef L_SHAPE_ROUTE_CAPACITY_ENGINE_TOP_ASSERT_SVH
`define L_SHAPE_ROUTE_CAPACITY_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTH
// property that must hold in the same cycle as its antecedent
`define LSRCE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property whose consequent must hold in the cycle after its antecedent
`define LSRCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSRCE_ASSERT(lbl, clk, rstn, prop, msg)
`define LSRCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/lsrce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrce_pkg
// shared types and constants of the l-shape route capacity engine
// ----------------------------------------------------------------------------
package lsrce_pkg;

  // field widths
  localparam int CW       = 8;   // coordinate width
  localparam int CFGW     = 10;  // capacity register width
  localparam int CAPW     = 12;  // stored edge capacity width
  localparam int CFG_IDXW = 1;   // register index width

  // default grid size
  localparam int GRID_W_DEF = 256;
  localparam int GRID_H_DEF = 256;

  // command queue depth
  localparam int QDEPTH = 2;

  // request modes
  localparam logic [1:0] MODE_ROUTE = 2'd0;
  localparam logic [1:0] MODE_RIPUP = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  // register indexes
  localparam logic [CFG_IDXW-1:0] CFG_HORIZ_INIT = 1'd0;
  localparam logic [CFG_IDXW-1:0] CFG_VERT_INIT  = 1'd1;

  // capacity saturation limits
  localparam logic signed [CAPW-1:0] CAP_MIN = 12'sh800;
  localparam logic signed [CAPW-1:0] CAP_MAX = 12'sh7FF;

  // classified command
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_ROUTE,
    CMD_RIPUP,
    CMD_INIT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e         op;
    logic            has_bend;
    logic [CW-1:0]   col;   // source column, vertical leg
    logic [CW-1:0]   row;   // sink row, horizontal leg
    logic [CW-1:0]   y_lo;
    logic [CW-1:0]   y_hi;
    logic [CW-1:0]   x_lo;
    logic [CW-1:0]   x_hi;
  } cmd_t;

endpackage

>>> design/l_shape_route_capacity_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l_shape_route_capacity_engine_top
// grid edge capacity tracker for l-shaped net routing
// ----------------------------------------------------------------------------
// Requests enter on in_valid_i / in_stall_o with mode and source / sink cells.
// Each accepted word gives exactly one result word on out_valid_o /
// out_stall_i, in request order. The user must write the capacity registers
// through cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle; the
// block itself does not enforce this.
// A two-entry command queue sits between the classifier and the path walker,
// so up to two requests are taken while the walker is busy.
// Route and rip-up walk one edge per cycle through a read-modify-write on the
// edge ram. Init sweeps one ram address per cycle through both rams.
// After reset the same sweep clears every edge to zero; in_stall_o stays high
// until it ends.
// A stalled result waits in the output register while the walker goes on
// with the next request; it stops only when a second result is ready.
// ----------------------------------------------------------------------------
module l_shape_route_capacity_engine_top #(
  parameter int GRID_W = lsrce_pkg::GRID_W_DEF,
  parameter int GRID_H = lsrce_pkg::GRID_H_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsrce_pkg::CFG_IDXW-1:0] cfg_idx_i,
  input  logic [lsrce_pkg::CFGW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [lsrce_pkg::CW-1:0]       src_x_i,
  input  logic [lsrce_pkg::CW-1:0]       src_y_i,
  input  logic [lsrce_pkg::CW-1:0]       dst_x_i,
  input  logic [lsrce_pkg::CW-1:0]       dst_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           overflow_o,
  output logic                           has_bend_o,
  output logic [lsrce_pkg::CW-1:0]       bend_x_o,
  output logic [lsrce_pkg::CW-1:0]       bend_y_o
);
  import lsrce_pkg::*;

  logic [CFGW-1:0] horiz_init_q;
  logic [CFGW-1:0] vert_init_q;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  logic            boot_clear;
  cmd_t            cmd_in;
  cmd_t            cmd_out;

  // capacity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horiz_init_q <= '0;
      vert_init_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HORIZ_INIT: horiz_init_q <= cfg_data_i;
        CFG_VERT_INIT:  vert_init_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsrce_front #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .src_x_i      (src_x_i),
    .src_y_i      (src_y_i),
    .dst_x_i      (dst_x_i),
    .dst_y_i      (dst_y_i),
    .q_full_i     (q_full),
    .boot_clear_i (boot_clear),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  lsrce_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .dout_o  (cmd_out),
    .empty_o (q_empty)
  );

  lsrce_back #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_dout_i     (cmd_out),
    .q_pop_o      (pop),
    .cfg_horiz_i  (horiz_init_q),
    .cfg_vert_i   (vert_init_q),
    .boot_clear_o (boot_clear),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .overflow_o   (overflow_o),
    .has_bend_o   (has_bend_o),
    .bend_x_o     (bend_x_o),
    .bend_y_o     (bend_y_o)
  );

endmodule

>>> design/lsrce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrce_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lsrce_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lsrce_fifo.sv
`timescale 1ns / 1ps
`include "l_shape_route_capacity_engine_top_assert.svh"
// ----------------------------------------------------------------------------
// lsrce_fifo
// short command queue between the front classifier and the back walker
// ----------------------------------------------------------------------------
module lsrce_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsrce_pkg::cmd_t     din_i,
  output logic                full_o,
  input  logic                pop_i,
  output lsrce_pkg::cmd_t     dout_o,
  output logic                empty_o
);
  import lsrce_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          entry_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? PW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? PW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= din_i;
    end
  end

  `LSRCE_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")
  `LSRCE_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> !empty_o, "pop from empty queue")

endmodule

>>> design/lsrce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrce_front
// accepts request words, checks the grid bounds and classifies them
// ----------------------------------------------------------------------------
module lsrce_front #(
  parameter int GRID_W = lsrce_pkg::GRID_W_DEF,
  parameter int GRID_H = lsrce_pkg::GRID_H_DEF
) (
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [lsrce_pkg::CW-1:0] src_x_i,
  input  logic [lsrce_pkg::CW-1:0] src_y_i,
  input  logic [lsrce_pkg::CW-1:0] dst_x_i,
  input  logic [lsrce_pkg::CW-1:0] dst_y_i,
  input  logic                    q_full_i,
  input  logic                    boot_clear_i,
  output logic                    push_o,
  output lsrce_pkg::cmd_t         cmd_o
);
  import lsrce_pkg::*;

  logic on_grid;
  logic walk;

  // hold off while the queue is full or the grid is still being cleared
  assign in_stall_o = q_full_i | boot_clear_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  assign on_grid = (32'(src_x_i) < 32'(GRID_W)) && (32'(dst_x_i) < 32'(GRID_W)) &&
                   (32'(src_y_i) < 32'(GRID_H)) && (32'(dst_y_i) < 32'(GRID_H));

  assign walk = (mode_i inside {MODE_ROUTE, MODE_RIPUP}) && on_grid;

  // classify and precompute the path ranges
  always_comb begin
    cmd_o = '0;
    case (mode_i)
      MODE_ROUTE: cmd_o.op = on_grid ? CMD_ROUTE : CMD_NOP;
      MODE_RIPUP: cmd_o.op = on_grid ? CMD_RIPUP : CMD_NOP;
      MODE_INIT:  cmd_o.op = CMD_INIT;
      default:    cmd_o.op = CMD_NOP;
    endcase
    if (walk) begin
      cmd_o.has_bend = (src_x_i != dst_x_i) && (src_y_i != dst_y_i);
      cmd_o.col      = src_x_i;
      cmd_o.row      = dst_y_i;
      cmd_o.y_lo     = (src_y_i < dst_y_i) ? src_y_i : dst_y_i;
      cmd_o.y_hi     = (src_y_i < dst_y_i) ? dst_y_i : src_y_i;
      cmd_o.x_lo     = (src_x_i < dst_x_i) ? src_x_i : dst_x_i;
      cmd_o.x_hi     = (src_x_i < dst_x_i) ? dst_x_i : src_x_i;
    end
  end

endmodule

>>> design/lsrce_back.sv
`timescale 1ns / 1ps
`include "l_shape_route_capacity_engine_top_assert.svh"
// ----------------------------------------------------------------------------
// lsrce_back
// walks the l path one edge per cycle, fills the grid, drives the result word
// ----------------------------------------------------------------------------
module lsrce_back #(
  parameter int GRID_W = lsrce_pkg::GRID_W_DEF,
  parameter int GRID_H = lsrce_pkg::GRID_H_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  lsrce_pkg::cmd_t            q_dout_i,
  output logic                       q_pop_o,
  input  logic [lsrce_pkg::CFGW-1:0] cfg_horiz_i,
  input  logic [lsrce_pkg::CFGW-1:0] cfg_vert_i,
  output logic                       boot_clear_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       overflow_o,
  output logic                       has_bend_o,
  output logic [lsrce_pkg::CW-1:0]   bend_x_o,
  output logic [lsrce_pkg::CW-1:0]   bend_y_o
);
  import lsrce_pkg::*;

  localparam int XW    = (GRID_W > (2**CW)) ? CW : $clog2(GRID_W);
  localparam int YW    = (GRID_H > (2**CW)) ? CW : $clog2(GRID_H);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2**AW;

  localparam logic [2:0] ST_FILL  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_VERT  = 3'd2;
  localparam logic [2:0] ST_HORIZ = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]             state_q;
  cmd_t                   cmd_q;
  logic [CW-1:0]          k_q;
  logic [AW-1:0]          fill_addr_q;
  logic [CAPW-1:0]        fill_h_q, fill_v_q;
  logic                   fill_rsp_q;
  logic                   rd_pend_q;
  logic                   rd_vert_q;
  logic [AW-1:0]          rd_addr_q;
  logic                   neg_q;
  logic                   res_vld_q;
  logic                   res_ovf_q, res_bend_q;
  logic [CW-1:0]          res_x_q, res_y_q;

  logic                   issue_v, issue_h;
  logic                   res_take;
  logic                   res_load;
  logic                   filling;
  logic [AW-1:0]          vert_raddr, horiz_raddr;
  logic [CAPW-1:0]        v_rdata, h_rdata;
  logic signed [CAPW-1:0] rdata, adj;
  logic                   is_dec;
  logic                   v_we, h_we;
  logic [AW-1:0]          v_waddr, h_waddr;
  logic [CAPW-1:0]        v_wdata, h_wdata;

  // read addresses of both legs
  assign vert_raddr  = {cmd_q.col[XW-1:0], k_q[YW-1:0]};
  assign horiz_raddr = {k_q[XW-1:0], cmd_q.row[YW-1:0]};

  assign issue_v  = (state_q == ST_VERT) && (k_q < cmd_q.y_hi);
  assign issue_h  = (state_q == ST_HORIZ) && (k_q < cmd_q.x_hi);
  assign res_take = ~res_vld_q | ~out_stall_i;
  assign res_load = (state_q == ST_OUT) && res_take;
  assign filling  = (state_q == ST_FILL);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  assign boot_clear_o = filling && !fill_rsp_q;

  // saturating edge update on the returned read data
  assign is_dec = (cmd_q.op == CMD_ROUTE);
  assign rdata  = rd_vert_q ? v_rdata : h_rdata;
  always_comb begin
    if (is_dec) begin
      adj = (rdata == CAP_MIN) ? rdata : rdata - CAPW'(1);
    end else begin
      adj = (rdata == CAP_MAX) ? rdata : rdata + CAPW'(1);
    end
  end

  // write port select: grid fill or edge write-back
  always_comb begin
    if (filling) begin
      v_we    = 1'b1;
      h_we    = 1'b1;
      v_waddr = fill_addr_q;
      h_waddr = fill_addr_q;
      v_wdata = fill_v_q;
      h_wdata = fill_h_q;
    end else begin
      v_we    = rd_pend_q & rd_vert_q;
      h_we    = rd_pend_q & ~rd_vert_q;
      v_waddr = rd_addr_q;
      h_waddr = rd_addr_q;
      v_wdata = adj;
      h_wdata = adj;
    end
  end

  lsrce_ram #(
    .WIDTH (CAPW),
    .DEPTH (DEPTH)
  ) u_vert_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (vert_raddr),
    .rdata_o (v_rdata)
  );

  lsrce_ram #(
    .WIDTH (CAPW),
    .DEPTH (DEPTH)
  ) u_horiz_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (horiz_raddr),
    .rdata_o (h_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      k_q         <= '0;
      fill_addr_q <= '0;
      fill_h_q    <= '0;
      fill_v_q    <= '0;
      fill_rsp_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
      neg_q       <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      rd_pend_q <= issue_v | issue_h;
      if (rd_pend_q && is_dec && adj[CAPW-1]) begin
        neg_q <= 1'b1;
      end
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        ST_FILL: begin
          fill_addr_q <= AW'(fill_addr_q + 1'b1);
          if (fill_addr_q == '1) begin
            state_q <= fill_rsp_q ? ST_OUT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty_i) begin
            neg_q <= 1'b0;
            case (q_dout_i.op)
              CMD_ROUTE, CMD_RIPUP: begin
                k_q     <= q_dout_i.y_lo;
                state_q <= ST_VERT;
              end
              CMD_INIT: begin
                fill_h_q    <= CAPW'(cfg_horiz_i);
                fill_v_q    <= CAPW'(cfg_vert_i);
                fill_rsp_q  <= 1'b1;
                fill_addr_q <= '0;
                state_q     <= ST_FILL;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_VERT: begin
          if (issue_v) begin
            k_q <= k_q + 1'b1;
          end else begin
            k_q     <= cmd_q.x_lo;
            state_q <= ST_HORIZ;
          end
        end
        ST_HORIZ: begin
          if (issue_h) begin
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res_take) begin
            fill_rsp_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // command and read bookkeeping
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_dout_i;
    end
    rd_vert_q <= issue_v;
    rd_addr_q <= issue_v ? vert_raddr : horiz_raddr;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_ovf_q  <= neg_q & is_dec;
      res_bend_q <= cmd_q.has_bend;
      res_x_q    <= cmd_q.has_bend ? cmd_q.col : '0;
      res_y_q    <= cmd_q.has_bend ? cmd_q.row : '0;
    end
  end

  assign out_valid_o = res_vld_q;
  assign overflow_o  = res_ovf_q;
  assign has_bend_o  = res_bend_q;
  assign bend_x_o    = res_x_q;
  assign bend_y_o    = res_y_q;

  `LSRCE_ASSERT(a_pend, clk_i, rst_ni, rd_pend_q |-> $past(issue_v | issue_h), "stray edge write")
  `LSRCE_ASSERT(a_fill_no_pend, clk_i, rst_ni, filling |-> !rd_pend_q, "edge write during fill")
  `LSRCE_ASSERT_NEXT(a_out_loads, clk_i, rst_ni, res_load, res_vld_q, "result not loaded")

endmodule
